// ===== design/audio_frame_window_statistics_top_macros.svh =====
// ----------------------------------------------------------------------------
// audio frame window statistics assertion macros
// concurrent property helpers used by the afws_checker file
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_WINDOW_STATISTICS_TOP_MACROS_SVH
`define AUDIO_FRAME_WINDOW_STATISTICS_TOP_MACROS_SVH

// same-cycle implication
`define AFWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AFWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/afws_pkg.sv =====
// ----------------------------------------------------------------------------
// afws_pkg
// types, constants and helper functions for the frame window statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package afws_pkg;

   localparam int              WINDOW_BITS   = 8;
   localparam logic [7:0]      WINDOW_RESET  = 8'd33;
   localparam logic [8:0]      FRAME_SAMPLES = 9'd256;
   localparam int              DIV_BITS      = 32;
   localparam int              DVSR_BITS     = 16;
   localparam int              DIV_CNT_BITS  = $clog2(DIV_BITS);

   typedef struct packed {
      logic signed [15:0] frame_peak;
      logic        [8:0]  over_count;
      logic signed [23:0] mean_all_q8;
      logic signed [23:0] mean_over_q8;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] mean_peak;
      logic        [14:0] peak_hold;
      logic        [8:0]  over_count_per_frame;
      logic signed [15:0] mean_of_means;
      logic signed [15:0] mean_over_threshold;
   } rsp_data_type;

   typedef struct packed {
      logic signed [15:0]           frame_peak;
      logic        [8:0]            over_count;
      logic                         hit;
      logic signed [23:0]           mean_all_q8;
      logic signed [23:0]           mean_over_q8;
      logic                         last;
      logic        [WINDOW_BITS-1:0] frame_count;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  dividend;
      logic [DVSR_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      OP_PEAK = 2'd0,
      OP_OVER = 2'd1,
      OP_ALL  = 2'd2,
      OP_HIT  = 2'd3
   } div_op_type;

   function automatic logic [DIV_BITS-1:0] magnitude(input logic [DIV_BITS-1:0] value);
      logic [DIV_BITS-1:0] result;
      if (value[DIV_BITS-1]) begin
         result = ~value + DIV_BITS'(1);
      end else begin
         result = value;
      end
      return result;
   endfunction

   function automatic logic [15:0] sat_s16(input logic neg, input logic [DIV_BITS-1:0] mag);
      logic [15:0] result;
      if (neg) begin
         if (mag > DIV_BITS'(32768)) begin
            result = 16'h8000;
         end else begin
            result = ~mag[15:0] + 16'd1;
         end
      end else if (mag > DIV_BITS'(32767)) begin
         result = 16'h7FFF;
      end else begin
         result = mag[15:0];
      end
      return result;
   endfunction

   function automatic logic [8:0] sat_u9(input logic [DIV_BITS-1:0] mag);
      logic [8:0] result;
      if (mag > DIV_BITS'(511)) begin
         result = 9'h1FF;
      end else begin
         result = mag[8:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/audio_frame_window_statistics_top.sv =====
// ----------------------------------------------------------------------------
// audio_frame_window_statistics_top
// per-window block average with peak hold over microphone frame summaries
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   afws_pkg::req_data_type
//   rsp       out         rsp_valid / rsp_ready   afws_pkg::rsp_data_type
//   csr       in          csr_wr_en               csr_wr_data, frames per window
//
// one frame transaction per cycle enters the queue while it has room; the
// back end folds one queued frame into the sums per cycle while it is
// accumulating; at window end the shared restoring divider runs four
// quotients in turn before the result is registered
// synchronous active-high reset clears all sums and the queue
// a waiting result does not stop the next window from accumulating
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_window_statistics_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [7:0]              csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  afws_pkg::req_data_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output afws_pkg::rsp_data_type  rsp_data
);

   afws_pkg::fifo_status_type  fifo_status;
   afws_pkg::queue_entry_type  push_entry;
   afws_pkg::queue_entry_type  pop_entry;
   afws_pkg::div_req_type      div_req;
   afws_pkg::div_rsp_type      div_rsp;
   logic                       push;
   logic                       pop;

   afws_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_ready   (req_ready),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   afws_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (fifo_status)
   );

   afws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   afws_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/afws_front.sv =====
// ----------------------------------------------------------------------------
// afws_front
// accepts frame summaries, clamps the over count and marks the window end
// ----------------------------------------------------------------------------
`default_nettype none

module afws_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [7:0]                 csr_wr_data,
   input  logic                       req_valid,
   input  afws_pkg::req_data_type     req_data,
   output logic                       req_ready,
   input  afws_pkg::fifo_status_type  fifo_status,
   output logic                       push,
   output afws_pkg::queue_entry_type  push_entry
);

   logic [7:0] frames_per_window_ff, frames_per_window_in;
   logic [7:0] frame_counter_ff, frame_counter_in;
   logic [7:0] limit;
   logic [7:0] count_next;
   logic       last;

   assign req_ready  = !fifo_status.full;
   assign push       = req_valid && req_ready;
   assign limit      = (frames_per_window_ff == 8'd0) ? 8'd1 : frames_per_window_ff;
   assign count_next = frame_counter_ff + 8'd1;
   assign last       = (count_next >= limit);

   always_comb begin
      push_entry.frame_peak   = req_data.frame_peak;
      push_entry.over_count   = (req_data.over_count > afws_pkg::FRAME_SAMPLES) ?
                                afws_pkg::FRAME_SAMPLES : req_data.over_count;
      push_entry.hit          = |req_data.over_count;
      push_entry.mean_all_q8  = req_data.mean_all_q8;
      push_entry.mean_over_q8 = req_data.mean_over_q8;
      push_entry.last         = last;
      push_entry.frame_count  = count_next;
   end

   always_comb begin
      frames_per_window_in = csr_wr_en ? csr_wr_data : frames_per_window_ff;
      frame_counter_in     = frame_counter_ff;
      if (push) begin
         frame_counter_in = last ? 8'd0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_per_window_ff <= afws_pkg::WINDOW_RESET;
         frame_counter_ff     <= 8'd0;
      end else begin
         frames_per_window_ff <= frames_per_window_in;
         frame_counter_ff     <= frame_counter_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/afws_fifo.sv =====
// ----------------------------------------------------------------------------
// afws_fifo
// short queue of classified frame transactions between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module afws_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  afws_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output afws_pkg::queue_entry_type  pop_entry,
   output afws_pkg::fifo_status_type  status
);

   localparam int                    PTR_BITS = $clog2(DEPTH);
   localparam int                    CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0]   FULL_CNT = CNT_BITS'(DEPTH);

   afws_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign pop_entry    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/afws_div.sv =====
// ----------------------------------------------------------------------------
// afws_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module afws_div (
   input  logic                   clock,
   input  logic                   reset,
   input  afws_pkg::div_req_type  div_req,
   output afws_pkg::div_rsp_type  div_rsp
);

   localparam int DB = afws_pkg::DIV_BITS;
   localparam int VB = afws_pkg::DVSR_BITS;
   localparam int CB = afws_pkg::DIV_CNT_BITS;

   logic [DB-1:0] quot_ff, quot_in;
   logic [VB-1:0] rem_ff, rem_in;
   logic [VB-1:0] divisor_ff, divisor_in;
   logic [CB-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VB:0]   rem_shift;
   logic [VB:0]   rem_sub;

   assign rem_shift        = {rem_ff, quot_ff[DB-1]};
   assign rem_sub          = rem_shift - {1'b0, divisor_ff};
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         quot_in    = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[VB]) begin
            rem_in  = rem_sub[VB-1:0];
            quot_in = {quot_ff[DB-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[VB-1:0];
            quot_in = {quot_ff[DB-2:0], 1'b0};
         end
         count_in = count_ff + CB'(1);
         if (count_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

`default_nettype wire

// ===== design/afws_back.sv =====
// ----------------------------------------------------------------------------
// afws_back
// window accumulators, quotient sequencing and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module afws_back (
   input  logic                       clock,
   input  logic                       reset,
   input  afws_pkg::fifo_status_type  fifo_status,
   input  afws_pkg::queue_entry_type  pop_entry,
   output logic                       pop,
   output afws_pkg::div_req_type      div_req,
   input  afws_pkg::div_rsp_type      div_rsp,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output afws_pkg::rsp_data_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_ACCUM = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   afws_pkg::div_op_type     op_ff, op_in;
   logic signed [23:0]       peak_sum_ff, peak_sum_in;
   logic signed [15:0]       peak_max_ff, peak_max_in;
   logic        [16:0]       over_sum_ff, over_sum_in;
   logic        [7:0]        hit_count_ff, hit_count_in;
   logic signed [31:0]       all_sum_ff, all_sum_in;
   logic signed [31:0]       hit_sum_ff, hit_sum_in;
   logic        [7:0]        frames_ff, frames_in;
   afws_pkg::rsp_data_type   res_ff, res_in;
   afws_pkg::rsp_data_type   rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     neg;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = (state_ff == ST_ACCUM) && !fifo_status.empty;

   // operand selection
   always_comb begin
      div_req.start = (state_ff == ST_LOAD);
      case (op_ff)
         afws_pkg::OP_PEAK: begin
            neg              = peak_sum_ff[23];
            div_req.dividend = afws_pkg::magnitude({{8{peak_sum_ff[23]}}, peak_sum_ff});
            div_req.divisor  = {8'd0, frames_ff};
         end
         afws_pkg::OP_OVER: begin
            neg              = 1'b0;
            div_req.dividend = {15'd0, over_sum_ff};
            div_req.divisor  = {8'd0, frames_ff};
         end
         afws_pkg::OP_ALL: begin
            neg              = all_sum_ff[31];
            div_req.dividend = afws_pkg::magnitude(all_sum_ff);
            div_req.divisor  = {frames_ff, 8'd0};
         end
         default: begin
            neg              = hit_sum_ff[31];
            div_req.dividend = afws_pkg::magnitude(hit_sum_ff);
            div_req.divisor  = {hit_count_ff, 8'd0};
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      peak_sum_in  = peak_sum_ff;
      peak_max_in  = peak_max_ff;
      over_sum_in  = over_sum_ff;
      hit_count_in = hit_count_ff;
      all_sum_in   = all_sum_ff;
      hit_sum_in   = hit_sum_ff;
      frames_in    = frames_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_ACCUM: begin
            if (pop) begin
               peak_sum_in  = peak_sum_ff + {{8{pop_entry.frame_peak[15]}}, pop_entry.frame_peak};
               if ($signed(pop_entry.frame_peak) > peak_max_ff) begin
                  peak_max_in = pop_entry.frame_peak;
               end
               over_sum_in  = over_sum_ff + {8'd0, pop_entry.over_count};
               hit_count_in = hit_count_ff + {7'd0, pop_entry.hit};
               all_sum_in   = all_sum_ff +
                              {{8{pop_entry.mean_all_q8[23]}}, pop_entry.mean_all_q8};
               hit_sum_in   = hit_sum_ff +
                              {{8{pop_entry.mean_over_q8[23]}}, pop_entry.mean_over_q8};
               if (pop_entry.last) begin
                  frames_in = pop_entry.frame_count;
                  op_in     = afws_pkg::OP_PEAK;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_LOAD;
               case (op_ff)
                  afws_pkg::OP_PEAK: begin
                     res_in.mean_peak = afws_pkg::sat_s16(neg, div_rsp.quotient);
                     op_in            = afws_pkg::OP_OVER;
                  end
                  afws_pkg::OP_OVER: begin
                     res_in.over_count_per_frame = afws_pkg::sat_u9(div_rsp.quotient);
                     op_in                       = afws_pkg::OP_ALL;
                  end
                  afws_pkg::OP_ALL: begin
                     res_in.mean_of_means = afws_pkg::sat_s16(neg, div_rsp.quotient);
                     op_in                = afws_pkg::OP_HIT;
                  end
                  default: begin
                     res_in.mean_over_threshold = (hit_count_ff == 8'd0) ? 16'sd0 :
                                                  afws_pkg::sat_s16(neg, div_rsp.quotient);
                     state_in                   = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in           = res_ff;
               rsp_data_in.peak_hold = peak_max_ff[14:0];
               rsp_valid_in          = 1'b1;
               peak_sum_in           = '0;
               peak_max_in           = '0;
               over_sum_in           = '0;
               hit_count_in          = '0;
               all_sum_in            = '0;
               hit_sum_in            = '0;
               state_in              = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         op_ff        <= afws_pkg::OP_PEAK;
         peak_sum_ff  <= '0;
         peak_max_ff  <= '0;
         over_sum_ff  <= '0;
         hit_count_ff <= '0;
         all_sum_ff   <= '0;
         hit_sum_ff   <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         peak_sum_ff  <= peak_sum_in;
         peak_max_ff  <= peak_max_in;
         over_sum_ff  <= over_sum_in;
         hit_count_ff <= hit_count_in;
         all_sum_ff   <= all_sum_in;
         hit_sum_ff   <= hit_sum_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/afws_checker.sv =====
// ----------------------------------------------------------------------------
// afws_checker
// port-level checks on the result channel of the statistics block
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_frame_window_statistics_top_macros.svh"

module afws_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input afws_pkg::rsp_data_type  rsp_data
);

   `AFWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result transaction changed")

   `AFWS_ASSERT_SAME(a_over_range, clock, reset, rsp_valid, rsp_data.over_count_per_frame <= 9'd256, "over count per frame above frame size")

   `AFWS_ASSERT_SAME(a_mean_le_max, clock, reset, rsp_valid, $signed(rsp_data.mean_peak) <= $signed(16'(rsp_data.peak_hold)), "mean peak above peak hold")

endmodule

bind audio_frame_window_statistics_top afws_checker u_afws_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/afws_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afws_window_checker
// watches the frame, result and csr ports of the window statistics block,
// keeps its own window sums and frame count, predicts each window result
// and compares every result transaction field by field in arrival order
// ----------------------------------------------------------------------------
module afws_window_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  afws_pkg::req_data_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  afws_pkg::rsp_data_type rsp_data,
   output int                     mismatch_count,
   output int                     pending_results,
   output int                     windows_checked
);

   import afws_pkg::*;

   logic [7:0]         window_length;
   logic [7:0]         frames_in_window;
   logic signed [23:0] peak_total;
   logic signed [15:0] peak_high;
   logic [16:0]        over_total;
   logic [7:0]         hit_frames;
   logic signed [31:0] all_mean_total;
   logic signed [31:0] over_mean_total;

   rsp_data_type expected_windows[$];
   rsp_data_type oldest_window;

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      windows_checked = 0;
   end

   function automatic longint clamp(input longint value, input longint lo, input longint hi);
      if (value < lo) begin
         return lo;
      end
      if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   task automatic clear_window();
      frames_in_window = '0;
      peak_total       = '0;
      peak_high        = '0;
      over_total       = '0;
      hit_frames       = '0;
      all_mean_total   = '0;
      over_mean_total  = '0;
   endtask

   task automatic accumulate_frame(input req_data_type frame);
      logic [8:0]   count;
      longint       frames;
      int           limit;
      rsp_data_type window_result;
      count = (frame.over_count > FRAME_SAMPLES) ? FRAME_SAMPLES : frame.over_count;
      peak_total = peak_total + 24'($signed(frame.frame_peak));
      if ($signed(frame.frame_peak) > peak_high) begin
         peak_high = frame.frame_peak;
      end
      over_total = over_total + 17'(count);
      if (count != 0) begin
         hit_frames = hit_frames + 8'd1;
      end
      all_mean_total  = all_mean_total + 32'($signed(frame.mean_all_q8));
      over_mean_total = over_mean_total + 32'($signed(frame.mean_over_q8));
      frames_in_window = frames_in_window + 8'd1;

      limit = (window_length == 0) ? 1 : int'(window_length);
      if (int'(frames_in_window) >= limit) begin
         frames = longint'(frames_in_window);
         window_result.mean_peak =
            16'(clamp(longint'(peak_total) / frames, -32768, 32767));
         window_result.peak_hold = 15'(clamp(longint'(peak_high), 0, 32767));
         window_result.over_count_per_frame =
            9'(clamp(longint'(over_total) / frames, 0, 511));
         window_result.mean_of_means =
            16'(clamp(longint'(all_mean_total) / (frames * 256), -32768, 32767));
         if (hit_frames == 0) begin
            window_result.mean_over_threshold = '0;
         end else begin
            window_result.mean_over_threshold = 16'(clamp(
               longint'(over_mean_total) / (longint'(hit_frames) * 256), -32768, 32767));
         end
         expected_windows.push_back(window_result);
         clear_window();
      end
   endtask

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_length = WINDOW_RESET;
         clear_window();
         expected_windows.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_windows.size() == 0) begin
               $error("result transaction with no window result expected");
               mismatch_count++;
            end else begin
               oldest_window = expected_windows.pop_front();
               check_field("mean_peak", $signed(oldest_window.mean_peak),
                           $signed(rsp_data.mean_peak));
               check_field("peak_hold", oldest_window.peak_hold, rsp_data.peak_hold);
               check_field("over_count_per_frame", oldest_window.over_count_per_frame,
                           rsp_data.over_count_per_frame);
               check_field("mean_of_means", $signed(oldest_window.mean_of_means),
                           $signed(rsp_data.mean_of_means));
               check_field("mean_over_threshold", $signed(oldest_window.mean_over_threshold),
                           $signed(rsp_data.mean_over_threshold));
               windows_checked++;
            end
         end
         if (csr_wr_en) begin
            window_length = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            accumulate_frame(req_data);
         end
      end
      pending_results = expected_windows.size();
   end

endmodule

// ===== tb/audio_frame_window_statistics_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_frame_window_statistics_top_test
// drives frame summaries through the window statistics block in bursts,
// stalls the result side, switches the window length between phases
// (0, 1, 255, a shrink below a partial window and random lengths) and lets
// the checker predict and compare every window result
// ----------------------------------------------------------------------------
module audio_frame_window_statistics_top_test;

   import afws_pkg::*;

   localparam int RANDOM_FRAMES  = 1600;
   localparam int DRAIN_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DIRECTED_COUNT = 12;

   localparam req_data_type DIRECTED_FRAMES [0:DIRECTED_COUNT-1] = '{
      '{16'h8000, 9'd0,   24'h000100, 24'h000000},
      '{16'hFFFF, 9'd0,   24'hFFFF00, 24'h000000},
      '{16'h0000, 9'd3,   24'h7FFFFF, 24'h001000},
      '{16'h7FFF, 9'd256, 24'h800000, 24'h7FFFFF},
      '{16'h8000, 9'd0,   24'h800000, 24'h800000},
      '{16'h7FFF, 9'd511, 24'h7FFFFF, 24'h7FFFFF},
      '{16'h0000, 9'd257, 24'h0000FF, 24'hFFFF01},
      '{16'hFFFF, 9'd1,   24'hFFFF80, 24'h800000},
      '{16'h0001, 9'd255, 24'hFFFFFF, 24'h000001},
      '{16'h8001, 9'd128, 24'h000000, 24'hFFFFFF},
      '{16'h7FFF, 9'd0,   24'h7FFFFF, 24'h7FFFFF},
      '{16'h8000, 9'd256, 24'h800000, 24'h800000}
   };

   logic         clock;
   logic         reset       = 1'b1;
   logic         csr_wr_en   = 1'b0;
   logic [7:0]   csr_wr_data = '0;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_data_type req_data    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_data_type rsp_data;

   int mismatch_count;
   int pending_results;
   int windows_checked;
   int frames_sent;
   int window_settings;
   int stalled_cycles;

   audio_frame_window_statistics_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   afws_window_checker window_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .windows_checked (windows_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // result side stalls on its own segments
   initial begin
      int segment;
      int mode;
      stalled_cycles = 0;
      @(negedge reset);
      forever begin
         mode    = $urandom_range(0, 3);
         segment = (mode == 1) ? $urandom_range(1, 20) : $urandom_range(1, 60);
         repeat (segment) begin
            @(negedge clock);
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'b0;
               2:       rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   function automatic logic [23:0] signed_pick(input int bits);
      logic [23:0] value;
      value = 24'($urandom);
      case ($urandom_range(0, 15))
         0, 1:    value = 24'(1) << (bits - 1);
         2, 3:    value = (24'(1) << (bits - 1)) - 24'd1;
         4:       value = '0;
         5:       value = '1;
         default: ;
      endcase
      return value & ((24'(1) << bits) - 24'd1);
   endfunction

   task automatic send_frame(input req_data_type frame);
      req_valid <= 1'b1;
      req_data  <= frame;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic set_window(input logic [7:0] length);
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      window_settings++;
   endtask

   initial begin
      req_data_type frame;
      int           phase;
      int           phase_frames;
      int           zero_pct;
      int           burst_left;
      int           gap;
      bit           no_gaps;
      logic [7:0]   length;

      frames_sent     = 0;
      window_settings = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // partial window under the reset length, then shrink, then 0 and 1
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == 3) begin
            req_valid <= 1'b0;
            set_window(8'd2);
         end else if (i == 4) begin
            req_valid <= 1'b0;
            set_window(8'd0);
         end else if (i == 10) begin
            req_valid <= 1'b0;
            set_window(8'd1);
         end
         send_frame(DIRECTED_FRAMES[i]);
      end
      req_valid <= 1'b0;

      phase = 0;
      while (frames_sent < DIRECTED_COUNT + RANDOM_FRAMES) begin
         case (phase)
            0:       length = 8'd255;
            1:       length = 8'd1;
            default:
               case ($urandom_range(0, 6))
                  0:       length = 8'd0;
                  1:       length = 8'($urandom_range(1, 3));
                  2, 3:    length = 8'($urandom_range(2, 16));
                  4:       length = 8'($urandom_range(17, 64));
                  5:       length = 8'($urandom_range(65, 255));
                  default: length = 8'($urandom_range(4, 40));
               endcase
         endcase
         phase_frames = (phase == 0) ? 300 : $urandom_range(10, 120);
         case ($urandom_range(0, 3))
            0:       zero_pct = 0;
            1:       zero_pct = 25;
            2:       zero_pct = 60;
            default: zero_pct = 100;
         endcase
         no_gaps    = ($urandom_range(0, 3) == 0);
         burst_left = 0;
         set_window(length);

         repeat (phase_frames) begin
            if (burst_left == 0) begin
               gap = no_gaps ? 0 : $urandom_range(0, 12);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            frame.frame_peak = 16'(signed_pick(16));
            if ($urandom_range(0, 99) < zero_pct) begin
               frame.over_count = '0;
            end else begin
               case ($urandom_range(0, 7))
                  0:       frame.over_count = 9'd256;
                  1:       frame.over_count = 9'($urandom_range(257, 511));
                  default: frame.over_count = 9'($urandom_range(1, 256));
               endcase
            end
            frame.mean_all_q8 = signed_pick(24);
            if (frame.over_count == 0 && $urandom_range(0, 3) != 0) begin
               frame.mean_over_q8 = '0;
            end else begin
               frame.mean_over_q8 = signed_pick(24);
            end
            send_frame(frame);
         end
         req_valid <= 1'b0;
         phase++;
      end

      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d frames and %0d window results over %0d window settings",
               frames_sent, windows_checked, window_settings);
      $display("window lengths included 0, 1, 255 and a shrink below a partial window");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/afws_pkg.sv
design/afws_front.sv
design/afws_fifo.sv
design/afws_div.sv
design/afws_back.sv
design/audio_frame_window_statistics_top.sv
design/afws_checker.sv
tb/afws_window_checker.sv
tb/audio_frame_window_statistics_top_test.sv
